// ===== rtl/lsa_pkg.sv =====
// Package for the log sieve accumulator: sizes, command codes and the
// command word passed from the front end through the queue to the back end.
// No dependencies.
package lsa_pkg;

    // Sieve store geometry.
    localparam int SIEVE_DEPTH = 65536;
    localparam int SIEVE_AW    = $clog2(SIEVE_DEPTH);
    localparam int LEN_W       = SIEVE_AW + 1;

    // Field widths of an input word.
    localparam int ACT_W   = 2;
    localparam int PRIME_W = 24;
    localparam int SIZE_W  = 8;
    localparam int ROOT_W  = 24;
    localparam int POS_W   = 16;

    // A walk position is a root, or past the store by up to one prime.
    localparam int WALK_W = PRIME_W + 1;

    // Configuration registers.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;
    localparam logic [CFG_IDX_W-1:0] REG_FILL_VALUE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD     = 2'd2;
    localparam logic [CFG_DATA_W-1:0] ACTIVE_LENGTH_RST = 17'h10000;

    // Action codes carried on the input tuser.
    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SIEVE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;

    // Bus widths.
    localparam int S_DATA_W = 96;
    localparam int M_DATA_W = 16;

    // Command queue.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        KIND_NOP   = 2'd0,
        KIND_CLEAR = 2'd1,
        KIND_SIEVE = 2'd2,
        KIND_READ  = 2'd3
    } cmd_kind_t;

    // One classified command. For a clear, size carries the fill byte.
    typedef struct packed {
        cmd_kind_t               kind;
        logic [PRIME_W-1:0]      step;
        logic [SIZE_W-1:0]       size;
        logic [ROOT_W-1:0]       root_one;
        logic [ROOT_W-1:0]       root_two;
        logic [SIEVE_AW-1:0]     addr;
        logic [LEN_W-1:0]        len;
    } cmd_t;

endpackage

// ===== rtl/lsa_front.sv =====
// Front end of the log sieve accumulator: configuration registers and the
// classifier that turns an input word into a command. Depends on lsa_pkg.
module lsa_front (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [lsa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lsa_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [lsa_pkg::S_DATA_W-1:0]       s_tdata,
    input  logic [lsa_pkg::ACT_W-1:0]          s_tuser,
    input  logic                               q_full,
    output logic                               q_push,
    output lsa_pkg::cmd_t                      q_push_cmd,
    output logic [lsa_pkg::SIZE_W-1:0]         threshold
);

    logic [lsa_pkg::SIZE_W-1:0]      fill_reg;
    logic [lsa_pkg::CFG_DATA_W-1:0]  active_len_reg;
    logic [lsa_pkg::SIZE_W-1:0]      thr_reg;

    logic [lsa_pkg::PRIME_W-1:0]     f_prime;
    logic [lsa_pkg::SIZE_W-1:0]      f_size;
    logic [lsa_pkg::ROOT_W-1:0]      f_root_one;
    logic [lsa_pkg::ROOT_W-1:0]      f_root_two;
    logic [lsa_pkg::POS_W-1:0]       f_position;
    logic [lsa_pkg::LEN_W-1:0]       used_len;
    logic                            pos_in_range;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg       <= '0;
            active_len_reg <= lsa_pkg::ACTIVE_LENGTH_RST;
            thr_reg        <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                lsa_pkg::REG_FILL_VALUE:    fill_reg <= cfg_wdata[lsa_pkg::SIZE_W-1:0];
                lsa_pkg::REG_ACTIVE_LENGTH: active_len_reg <= cfg_wdata;
                lsa_pkg::REG_THRESHOLD:     thr_reg <= cfg_wdata[lsa_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    assign f_prime    = s_tdata[23:0];
    assign f_size     = s_tdata[31:24];
    assign f_root_one = s_tdata[55:32];
    assign f_root_two = s_tdata[79:56];
    assign f_position = s_tdata[95:80];

    // A length beyond the store is cut to the store depth.
    assign used_len = (32'(active_len_reg) > 32'(lsa_pkg::SIEVE_DEPTH))
                      ? lsa_pkg::LEN_W'(lsa_pkg::SIEVE_DEPTH)
                      : lsa_pkg::LEN_W'(active_len_reg);

    assign pos_in_range = (32'(f_position) < 32'(lsa_pkg::SIEVE_DEPTH));

    always_comb begin
        q_push_cmd.step     = f_prime;
        q_push_cmd.size     = f_size;
        q_push_cmd.root_one = f_root_one;
        q_push_cmd.root_two = f_root_two;
        q_push_cmd.addr     = lsa_pkg::SIEVE_AW'(f_position);
        q_push_cmd.len      = used_len;
        q_push_cmd.kind     = lsa_pkg::KIND_NOP;
        case (s_tuser)
            lsa_pkg::ACT_CLEAR: begin
                q_push_cmd.size = fill_reg;
                if (used_len != '0) begin
                    q_push_cmd.kind = lsa_pkg::KIND_CLEAR;
                end
            end
            lsa_pkg::ACT_SIEVE: begin
                // A zero second root means the prime is skipped.
                if (f_root_two != '0 && used_len != '0) begin
                    q_push_cmd.kind = lsa_pkg::KIND_SIEVE;
                end
            end
            lsa_pkg::ACT_READ: begin
                if (pos_in_range) begin
                    q_push_cmd.kind = lsa_pkg::KIND_READ;
                end
            end
            default: q_push_cmd.kind = lsa_pkg::KIND_NOP;
        endcase
    end

    assign s_tready  = !q_full;
    assign q_push    = s_tvalid && !q_full;
    assign threshold = thr_reg;

endmodule

// ===== rtl/lsa_cmd_queue.sv =====
// Short command queue between the front and back ends of the log sieve
// accumulator. Depends on lsa_pkg.
module lsa_cmd_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  lsa_pkg::cmd_t  push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output lsa_pkg::cmd_t  head_cmd
);

    lsa_pkg::cmd_t                entry_reg [lsa_pkg::QUEUE_DEPTH];
    logic [lsa_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [lsa_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [lsa_pkg::QPTR_W:0]     count_reg;
    logic [lsa_pkg::QPTR_W:0]     count_next;

    assign full       = (count_reg == (lsa_pkg::QPTR_W + 1)'(lsa_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/lsa_back.sv =====
// Back end of the log sieve accumulator: the sieve store, the sequencer for
// clear sweeps and prime walks, and the result register. Depends on lsa_pkg.
module lsa_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    input  lsa_pkg::cmd_t                 q_cmd,
    output logic                          q_pop,
    input  logic [lsa_pkg::SIZE_W-1:0]    threshold,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [lsa_pkg::M_DATA_W-1:0]  m_tdata
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CLEAR = 5'b00010,
        S_WALK  = 5'b00100,
        S_READ  = 5'b01000,
        S_DONE  = 5'b10000
    } back_state_t;

    back_state_t                     state_reg, state_next;
    lsa_pkg::cmd_t                   cmd_reg;
    logic [lsa_pkg::LEN_W-1:0]       cnt_reg, cnt_next;
    logic [lsa_pkg::WALK_W-1:0]      pos_reg, pos_next;
    logic                            walk_sel_reg, walk_sel_next;
    logic                            hit_vld_reg, hit_vld_next;
    logic [lsa_pkg::SIEVE_AW-1:0]    hit_addr_reg, hit_addr_next;

    logic [lsa_pkg::SIZE_W-1:0]      sieve_mem [lsa_pkg::SIEVE_DEPTH];
    logic [lsa_pkg::SIZE_W-1:0]      rdata_reg;
    logic                            mem_re, mem_we;
    logic [lsa_pkg::SIEVE_AW-1:0]    mem_raddr, mem_waddr;
    logic [lsa_pkg::SIZE_W-1:0]      mem_wdata;

    logic                            m_valid_reg;
    logic [lsa_pkg::SIZE_W-1:0]      m_value_reg;
    logic                            m_cand_reg;
    logic                            load_out;
    logic                            walk_pos_ok;

    assign walk_pos_ok = (pos_reg < lsa_pkg::WALK_W'(cmd_reg.len));

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        pos_next      = pos_reg;
        walk_sel_next = walk_sel_reg;
        hit_vld_next  = 1'b0;
        hit_addr_next = hit_addr_reg;
        q_pop         = 1'b0;
        mem_re        = 1'b0;
        mem_raddr     = lsa_pkg::SIEVE_AW'(pos_reg);
        mem_we        = 1'b0;
        mem_waddr     = lsa_pkg::SIEVE_AW'(cnt_reg);
        mem_wdata     = cmd_reg.size;
        load_out      = 1'b0;

        // Write back the hit whose byte was read in the previous cycle.
        if (hit_vld_reg) begin
            mem_we    = 1'b1;
            mem_waddr = hit_addr_reg;
            mem_wdata = rdata_reg + cmd_reg.size;
        end

        case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    q_pop = 1'b1;
                    case (q_cmd.kind)
                        lsa_pkg::KIND_CLEAR: begin
                            cnt_next   = '0;
                            state_next = S_CLEAR;
                        end
                        lsa_pkg::KIND_SIEVE: begin
                            pos_next      = lsa_pkg::WALK_W'(q_cmd.root_one);
                            walk_sel_next = 1'b0;
                            state_next    = S_WALK;
                        end
                        lsa_pkg::KIND_READ: state_next = S_READ;
                        default:            state_next = S_DONE;
                    endcase
                end
            end
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = lsa_pkg::SIEVE_AW'(cnt_reg);
                mem_wdata = cmd_reg.size;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg + 1'b1 == cmd_reg.len) begin
                    state_next = S_DONE;
                end
            end
            S_WALK: begin
                if (walk_pos_ok) begin
                    mem_re        = 1'b1;
                    mem_raddr     = lsa_pkg::SIEVE_AW'(pos_reg);
                    hit_vld_next  = 1'b1;
                    hit_addr_next = lsa_pkg::SIEVE_AW'(pos_reg);
                    // A zero prime hits its root once and stops.
                    if (cmd_reg.step == '0) begin
                        pos_next = lsa_pkg::WALK_W'(cmd_reg.len);
                    end else begin
                        pos_next = pos_reg + lsa_pkg::WALK_W'(cmd_reg.step);
                    end
                end else if (!walk_sel_reg) begin
                    // This cycle has no read, so the last write of the first
                    // walk lands before the second walk reads anything.
                    pos_next      = lsa_pkg::WALK_W'(cmd_reg.root_two);
                    walk_sel_next = 1'b1;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_READ: begin
                mem_re     = 1'b1;
                mem_raddr  = cmd_reg.addr;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            hit_vld_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            hit_vld_reg <= hit_vld_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cmd_reg <= q_cmd;
        end
        cnt_reg      <= cnt_next;
        pos_reg      <= pos_next;
        walk_sel_reg <= walk_sel_next;
        hit_addr_reg <= hit_addr_next;
        if (load_out) begin
            if (cmd_reg.kind == lsa_pkg::KIND_READ) begin
                m_value_reg <= rdata_reg;
                m_cand_reg  <= (rdata_reg > threshold);
            end else begin
                m_value_reg <= '0;
                m_cand_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            sieve_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= sieve_mem[mem_raddr];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(lsa_pkg::M_DATA_W - lsa_pkg::SIZE_W - 1){1'b0}},
                       m_cand_reg, m_value_reg};

endmodule

// ===== rtl/log_sieve_accumulator_core.sv =====
// Top level of the log sieve accumulator: front end, command queue and back
// end with the sieve store. Depends on lsa_pkg, lsa_front, lsa_cmd_queue, lsa_back.
//
//   Channel   Direction  Handshake          Payload
//   s_        in         s_tvalid/s_tready  s_tdata (96 bits), s_tuser (action)
//   m_        out        m_tvalid/m_tready  m_tdata (value, is_candidate)
//   cfg_      in         cfg_wr_en only     cfg_index, cfg_wdata
//
// Every input word gives exactly one result word. The back end owns one
// sieve store port pair (one write and one read a cycle): a clear writes
// each byte of the active length in turn, a sieve word reads and writes
// back each hit (about 2 * length / prime hits), and a read fetches one
// byte. Reset is synchronous and active low; the store itself is not
// cleared by reset and holds nothing meaningful until a clear word has run.
// A two-word queue lets the input side keep accepting while the back end is
// busy or a result waits on m_tready.
module log_sieve_accumulator_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Configuration writes: 0 fill value, 1 active length, 2 threshold.
    input  logic                               cfg_wr_en,
    input  logic [lsa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lsa_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // Input words.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // From bit 0: prime[23:0], log_size[31:24], root_one[55:32],
    // root_two[79:56], position[95:80].
    input  logic [lsa_pkg::S_DATA_W-1:0]       s_tdata,
    // action: 0 clear, 1 sieve with one prime, 2 read one position.
    input  logic [lsa_pkg::ACT_W-1:0]          s_tuser,
    // Result words.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // From bit 0: value[7:0], is_candidate[8], zeros above.
    output logic [lsa_pkg::M_DATA_W-1:0]       m_tdata
);

    logic                         q_full;
    logic                         q_push;
    lsa_pkg::cmd_t                q_push_cmd;
    logic                         q_pop;
    logic                         q_head_valid;
    lsa_pkg::cmd_t                q_head_cmd;
    logic [lsa_pkg::SIZE_W-1:0]   threshold;

    // The front end holds the registers and classifies each word into a
    // command, resolving skipped primes, empty lengths and out-of-range reads
    // into a no-operation that still produces a zero result.
    lsa_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_push_cmd (q_push_cmd),
        .threshold  (threshold)
    );

    lsa_cmd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (q_push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_cmd   (q_head_cmd)
    );

    // The back end runs one command at a time: a clear sweeps the store, a
    // sieve walks both roots with a read-modify-write pipeline, and a read
    // fetches one byte. The result sits in an output register.
    lsa_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_head_valid),
        .q_cmd     (q_head_cmd),
        .q_pop     (q_pop),
        .threshold (threshold),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for log_sieve_accumulator_core: a directed table followed by
// randomised phases of clear, sieve and read words, each result checked against a typed-in
// value or a behavioural image of the sieve store. Depends on lsa_pkg and the core RTL.
module tb_top;
    import lsa_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 3;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 64;
    localparam int CYCLE_LIMIT   = 5_000_000;
    localparam int RANDOM_WORDS  = 1100;
    localparam int PHASES        = 10;
    // Longer than any single word of the held phase, so that a finished result waits
    // on the receiver while the queue fills behind it.
    localparam int HOLD_CYCLES   = 3000;
    localparam int MAX_REPORTS   = 10;
    localparam int BIG_SPAN      = 4096;

    // Action three has no name in the package; the core must ignore it.
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic [ACT_W-1:0]   action;
        logic [PRIME_W-1:0] prime;
        logic [SIZE_W-1:0]  log_size;
        logic [ROOT_W-1:0]  root_one;
        logic [ROOT_W-1:0]  root_two;
        logic [POS_W-1:0]   position;
    } sieve_word_t;

    typedef struct packed {
        logic [7:0] value;
        logic       is_cand;
    } read_result_t;

    typedef enum logic {ROW_REG, ROW_WORD} row_kind_t;
    typedef enum logic {BY_MODEL, BY_HAND} row_check_t;

    typedef struct packed {
        row_kind_t              kind;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [CFG_DATA_W-1:0]  reg_val;
        sieve_word_t            word;
        row_check_t             check;
        read_result_t           expected;
    } row_t;

    localparam sieve_word_t  NO_WORD   = '0;
    localparam read_result_t NO_RESULT = '0;
    localparam int DIR_ROWS = 32;

    // Directed table. Rows marked BY_HAND carry the result typed in; the rest are
    // predicted. The first word clears the whole store, so every later read is legal.
    localparam row_t DIRECTED_ROWS [DIR_ROWS] = '{
        // After reset: full-length clear with fill 0, then reads at both ends.
        '{ROW_WORD, '0, '0, '{ACT_CLEAR, 24'd0, 8'd0, 24'd0, 24'd0, 16'd0},
          BY_HAND, '{8'd0, 1'b0}},
        '{ROW_WORD, '0, '0, '{ACT_READ, 24'd0, 8'd0, 24'd0, 24'd0, 16'd0},
          BY_HAND, '{8'd0, 1'b0}},
        '{ROW_WORD, '0, '0, '{ACT_READ, 24'hFFFFFF, 8'hFF, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF},
          BY_HAND, '{8'd0, 1'b0}},
        // Unused action with every field bit set.
        '{ROW_WORD, '0, '0, '{ACT_UNUSED, 24'hFFFFFF, 8'hFF, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF},
          BY_HAND, '{8'd0, 1'b0}},
        // Oversized active length acts as the full store.
        '{ROW_REG, REG_FILL_VALUE, 17'd255, NO_WORD, BY_MODEL, NO_RESULT},
        '{ROW_REG, REG_ACTIVE_LENGTH, 17'h1FFFF, NO_WORD, BY_MODEL, NO_RESULT},
        '{ROW_REG, REG_THRESHOLD, 17'd254, NO_WORD, BY_MODEL, NO_RESULT},
        '{ROW_WORD, '0, '0, '{ACT_SIEVE, 24'd40000, 8'd1, 24'd65535, 24'd25535, 16'd0},
          BY_HAND, '{8'd0, 1'b0}},
        '{ROW_WORD, '0, '0, '{ACT_READ, 24'd0, 8'd0, 24'd0, 24'd0, 16'd65535},
          BY_MODEL, NO_RESULT},
        // Zero active length: clear and sieve leave the store alone.
        '{ROW_REG, REG_ACTIVE_LENGTH, 17'd0, NO_WORD, BY_MODEL, NO_RESULT},
        '{ROW_WORD, '0, '0, '{ACT_CLEAR, 24'd0, 8'd0, 24'd0, 24'd0, 16'd0},
          BY_HAND, '{8'd0, 1'b0}},
        '{ROW_WORD, '0, '0, '{ACT_SIEVE, 24'd1, 8'd5, 24'd0, 24'd1, 16'd0},
          BY_HAND, '{8'd0, 1'b0}},
        '{ROW_WORD, '0, '0, '{ACT_READ, 24'd0, 8'd0, 24'd0, 24'd0, 16'd0},
          BY_MODEL, NO_RESULT},
        // Short store of sixteen bytes filled with 255.
        '{ROW_REG, REG_ACTIVE_LENGTH, 17'd16, NO_WORD, BY_MODEL, NO_RESULT},
        '{ROW_REG, REG_THRESHOLD, 17'd0, NO_WORD, BY_MODEL, NO_RESULT},
        '{ROW_WORD, '0, '0, '{ACT_CLEAR, 24'd0, 8'd0, 24'd0, 24'd0, 16'd0},
          BY_HAND, '{8'd0, 1'b0}},
        '{ROW_WORD, '0, '0, '{ACT_READ, 24'd0, 8'd0, 24'd0, 24'd0, 16'd15},
          BY_HAND, '{8'd255, 1'b1}},
        // Just past the active length: still holds the fill of the first clear.
        '{ROW_WORD, '0, '0, '{ACT_READ, 24'd0, 8'd0, 24'd0, 24'd0, 16'd16},
          BY_HAND, '{8'd0, 1'b0}},
        // Prime zero hits each root once; the byte wraps from 255 to 0.
        '{ROW_WORD, '0, '0, '{ACT_SIEVE, 24'd0, 8'd1, 24'd3, 24'd5, 16'd0},
          BY_HAND, '{8'd0, 1'b0}},
        '{ROW_WORD, '0, '0, '{ACT_READ, 24'd0, 8'd0, 24'd0, 24'd0, 16'd3},
          BY_MODEL, NO_RESULT},
        // Equal roots add twice.
        '{ROW_WORD, '0, '0, '{ACT_SIEVE, 24'd4, 8'd7, 24'd2, 24'd2, 16'd0},
          BY_HAND, '{8'd0, 1'b0}},
        // Root two zero skips the prime altogether.
        '{ROW_WORD, '0, '0, '{ACT_SIEVE, 24'd1, 8'd9, 24'd0, 24'd0, 16'd0},
          BY_HAND, '{8'd0, 1'b0}},
        // Roots at or above the prime still start the walks there.
        '{ROW_WORD, '0, '0, '{ACT_SIEVE, 24'd3, 8'd128, 24'd10, 24'd20, 16'd0},
          BY_HAND, '{8'd0, 1'b0}},
        // Largest prime and size; root two far beyond the store.
        '{ROW_WORD, '0, '0, '{ACT_SIEVE, 24'hFFFFFF, 8'd255, 24'd15, 24'hFFFFFF, 16'd0},
          BY_HAND, '{8'd0, 1'b0}},
        '{ROW_WORD, '0, '0, '{ACT_READ, 24'd0, 8'd0, 24'd0, 24'd0, 16'd2},
          BY_MODEL, NO_RESULT},
        '{ROW_WORD, '0, '0, '{ACT_READ, 24'd0, 8'd0, 24'd0, 24'd0, 16'd10},
          BY_MODEL, NO_RESULT},
        '{ROW_WORD, '0, '0, '{ACT_READ, 24'd0, 8'd0, 24'd0, 24'd0, 16'd15},
          BY_MODEL, NO_RESULT},
        // Single active byte and the highest threshold.
        '{ROW_REG, REG_THRESHOLD, 17'd255, NO_WORD, BY_MODEL, NO_RESULT},
        '{ROW_REG, REG_ACTIVE_LENGTH, 17'd1, NO_WORD, BY_MODEL, NO_RESULT},
        '{ROW_WORD, '0, '0, '{ACT_SIEVE, 24'd1, 8'd255, 24'd0, 24'd1, 16'd0},
          BY_HAND, '{8'd0, 1'b0}},
        '{ROW_WORD, '0, '0, '{ACT_READ, 24'd0, 8'd0, 24'd0, 24'd0, 16'd0},
          BY_MODEL, NO_RESULT},
        '{ROW_WORD, '0, '0, '{ACT_READ, 24'd0, 8'd0, 24'd0, 24'd0, 16'd14},
          BY_MODEL, NO_RESULT}
    };

    // Per-phase settings: active length, and idling in percent for each side.
    localparam int unsigned PHASE_LENGTHS [PHASES] =
        '{1, 37, 512, 0, 200, 65536, 300, 2, 131071, 400};
    localparam int SEND_IDLE [4] = '{0, 53, 0, 7};
    localparam int RECV_STALL [4] = '{0, 0, 53, 7};

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_DATA_W-1:0]    s_tdata   = '0;
    logic [ACT_W-1:0]       s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_DATA_W-1:0]    m_tdata;

    // Behavioural image of the core: store and register copies.
    logic [7:0]             sieve_image [SIEVE_DEPTH];
    logic [7:0]             fill_byte      = 8'd0;
    logic [CFG_DATA_W-1:0]  length_reg     = ACTIVE_LENGTH_RST;
    logic [7:0]             threshold_byte = 8'd0;
    read_result_t           pending_results [$];

    int send_idle_pct   = 7;
    int recv_stall_pct  = 7;
    int holds_requested = 0;
    int failures        = 0;
    int results_seen    = 0;
    int candidates_seen = 0;
    int counted_words   = 0;
    int word_tally [4]  = '{0, 0, 0, 0};
    longint cycle_count = 0;

    log_sieve_accumulator_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    function automatic int unsigned used_span();
        return (length_reg > CFG_DATA_W'(SIEVE_DEPTH)) ? SIEVE_DEPTH : int'(length_reg);
    endfunction

    // Applies one word to the store image and returns the result word it gives.
    function automatic read_result_t apply_word(sieve_word_t w);
        read_result_t    r;
        int unsigned     span;
        longint unsigned spot;
        longint unsigned roots [2];
        r = NO_RESULT;
        span = used_span();
        case (w.action)
            ACT_CLEAR: begin
                for (int i = 0; i < span; i++) sieve_image[i] = fill_byte;
            end
            ACT_SIEVE: begin
                if (w.root_two != '0) begin
                    roots[0] = w.root_one;
                    roots[1] = w.root_two;
                    foreach (roots[k]) begin
                        spot = roots[k];
                        while (spot < span) begin
                            sieve_image[spot] = sieve_image[spot] + w.log_size;
                            if (w.prime == '0) break;
                            spot = spot + w.prime;
                        end
                    end
                end
            end
            ACT_READ: begin
                r.value   = sieve_image[w.position];
                r.is_cand = (r.value > threshold_byte);
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // Random word. Sieve words mostly carry roots inside the active span and, for a small span,
    // primes small enough to hit several times; reads mostly land inside the span.
    function automatic sieve_word_t make_word(logic [ACT_W-1:0] act, int unsigned span,
                                              bit big);
        sieve_word_t w;
        int unsigned pick;
        w.action   = act;
        w.prime    = PRIME_W'($urandom);
        w.log_size = SIZE_W'($urandom);
        w.root_one = ROOT_W'($urandom);
        w.root_two = ROOT_W'($urandom);
        w.position = POS_W'($urandom);
        if (act == ACT_SIEVE) begin
            pick = $urandom_range(99);
            if (big) begin
                w.prime = (pick < 5) ? '0 : PRIME_W'($urandom_range(24'hFFFFFF, 2048));
            end else if (pick < 5) begin
                w.prime = '0;
            end else if (pick < 20) begin
                w.prime = PRIME_W'($urandom_range(4, 1));
            end else if (pick < 70) begin
                w.prime = PRIME_W'($urandom_range((span > 1) ? span : 1, 1));
            end
            if (span > 0 && $urandom_range(9) < 8)
                w.root_one = ROOT_W'($urandom_range(span - 1, 0));
            pick = $urandom_range(9);
            if (pick == 0) begin
                w.root_two = '0;
            end else if (pick == 1) begin
                w.root_two = w.root_one;
            end else if (pick < 9 && span > 0) begin
                w.root_two = ROOT_W'($urandom_range(span - 1, 0));
            end
        end else if (act == ACT_READ && span > 0 && $urandom_range(9) < 6) begin
            w.position = POS_W'($urandom_range(span - 1, 0));
        end
        return w;
    endfunction

    // Register write; the enable is left high so that writes may follow back to back.
    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            REG_FILL_VALUE:    fill_byte = val[7:0];
            REG_ACTIVE_LENGTH: length_reg = val;
            REG_THRESHOLD:     threshold_byte = val[7:0];
            default: begin
            end
        endcase
    endtask

    // Stops offering words and waits until every outstanding result has arrived.
    task automatic drain();
        s_tvalid  <= 1'b0;
        cfg_wr_en <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic offer_word(input sieve_word_t w, input row_check_t how,
                              input read_result_t given);
        read_result_t predicted;
        cfg_wr_en <= 1'b0;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= w.action;
        s_tdata  <= {w.position, w.root_two, w.root_one, w.log_size, w.prime};
        do @(posedge aclk); while (!s_tready);
        predicted = apply_word(w);
        pending_results.push_back((how == BY_HAND) ? given : predicted);
        word_tally[w.action]++;
        if (w.action != ACT_UNUSED) counted_words++;
    endtask

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    always @(posedge aclk) begin : result_ready
        int hold_left;
        int holds_served;
        if (holds_served != holds_requested) begin
            holds_served++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Every accepted result word is matched against the oldest prediction.
    always @(posedge aclk) begin : result_check
        read_result_t got;
        read_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.value   = m_tdata[7:0];
            got.is_cand = m_tdata[8];
            results_seen++;
            if (got.is_cand) candidates_seen++;
            if (pending_results.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("[%0t] unexpected result word: value %0d is_candidate %0d",
                             $realtime, got.value, got.is_cand);
            end else begin
                want = pending_results.pop_front();
                if (got != want) begin
                    failures++;
                    if (failures <= MAX_REPORTS)
                        $display("[%0t] result %0d: value exp %0d got %0d, %s exp %0d got %0d",
                                 $realtime, results_seen, want.value, got.value,
                                 "is_candidate", want.is_cand, got.is_cand);
                end
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    initial begin : stimulus
        int unsigned span;
        int          phase_start;
        bit          big;
        bit          paused;
        logic [7:0]  fill_pick;
        logic [7:0]  thr_pick;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (DIRECTED_ROWS[i]) begin
            if (DIRECTED_ROWS[i].kind == ROW_REG) begin
                drain();
                set_reg(DIRECTED_ROWS[i].reg_idx, DIRECTED_ROWS[i].reg_val);
            end else begin
                offer_word(DIRECTED_ROWS[i].word, DIRECTED_ROWS[i].check,
                           DIRECTED_ROWS[i].expected);
            end
        end

        // Random phases: mostly clear, sieve-batch, read-back sequences, with some noise.
        for (int p = 0; p < PHASES; p++) begin
            drain();
            fill_pick = (p == 0) ? 8'd255 : (p == 1) ? 8'd0 : 8'($urandom);
            thr_pick  = (p == 0) ? 8'd0 : (p == 1) ? 8'd255 : 8'($urandom);
            set_reg(REG_FILL_VALUE, {9'($urandom), fill_pick});
            set_reg(REG_ACTIVE_LENGTH, CFG_DATA_W'(PHASE_LENGTHS[p]));
            set_reg(REG_THRESHOLD, {9'($urandom), thr_pick});
            send_idle_pct  = SEND_IDLE[p % 4];
            recv_stall_pct = RECV_STALL[p % 4];
            span = used_span();
            big  = (span > BIG_SPAN);
            // One long receiver hold-off while words keep coming, to fill the queue.
            if (p == 2) holds_requested++;
            phase_start = counted_words;
            paused = 1'b0;
            while (counted_words - phase_start < RANDOM_WORDS / PHASES) begin
                if (!paused && counted_words - phase_start >= RANDOM_WORDS / PHASES / 2) begin
                    drain();
                    paused = 1'b1;
                end
                if ($urandom_range(99) < 15) begin
                    offer_word(make_word(ACT_W'($urandom_range(3)), span, big),
                               BY_MODEL, NO_RESULT);
                end else begin
                    if (!big && $urandom_range(3) != 0)
                        offer_word(make_word(ACT_CLEAR, span, big), BY_MODEL, NO_RESULT);
                    repeat ($urandom_range(8, 2))
                        offer_word(make_word(ACT_SIEVE, span, big), BY_MODEL, NO_RESULT);
                    repeat ($urandom_range(6, 1))
                        offer_word(make_word(ACT_READ, span, big), BY_MODEL, NO_RESULT);
                end
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Sent %0d clear, %0d sieve, %0d read and %0d unused-action words in %0d phases.",
                 word_tally[ACT_CLEAR], word_tally[ACT_SIEVE], word_tally[ACT_READ],
                 word_tally[ACT_UNUSED], PHASES);
        $display("Checked %0d result words, %0d candidates among them, %0d mismatches.",
                 results_seen, candidates_seen, failures);
        if (failures == 0 && pending_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== log_sieve_accumulator_core.f =====
rtl/lsa_pkg.sv
rtl/lsa_front.sv
rtl/lsa_cmd_queue.sv
rtl/lsa_back.sv
rtl/log_sieve_accumulator_core.sv
verif/tb_top.sv
